// ===== rtl/mts_pkg.sv =====
// Shared types and constants for the minimum-tracking stack.
`default_nettype none
package mts_pkg;

  localparam int          STACK_DEPTH = 256;
  localparam int          DATA_W      = 32;
  localparam logic [31:0] MOST_NEG    = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POP_EMPTY = 2'd2
  } status_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // shift command broadcast to every cell of a chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage
`default_nettype wire

// ===== rtl/mts_cell.sv =====
// One stack entry: loads from the cell above on push, from the cell below on pop.
`default_nettype none
module mts_cell (
  input  wire logic                     clk,
  input  wire mts_pkg::shift_t          ctrl,
  input  wire logic [mts_pkg::DATA_W-1:0] from_above,
  input  wire logic [mts_pkg::DATA_W-1:0] from_below,
  output      logic [mts_pkg::DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      q <= from_above;
    end else if (ctrl.pop) begin
      q <= from_below;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mts_chain.sv =====
// Row of stack cells; cell 0 is the top of stack.
`default_nettype none
module mts_chain #(
  parameter int DEPTH = mts_pkg::STACK_DEPTH
) (
  input  wire logic                       clk,
  input  wire mts_pkg::shift_t            ctrl,
  input  wire logic [mts_pkg::DATA_W-1:0] din,
  output      logic [mts_pkg::DATA_W-1:0] q0,
  output      logic [mts_pkg::DATA_W-1:0] q1
);

  logic [mts_pkg::DATA_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [mts_pkg::DATA_W-1:0] above;
    logic [mts_pkg::DATA_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = din;
    end else begin : g_mid
      assign above = q[i-1];
    end

    // bottom cell keeps its own word on pop; it is beyond the count anyway
    if (i == DEPTH - 1) begin : g_last
      assign below = q[i];
    end else begin : g_inner
      assign below = q[i+1];
    end

    mts_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .q          (q[i])
    );
  end

  assign q0 = q[0];
  assign q1 = q[1];

endmodule
`default_nettype wire

// ===== rtl/min_tracking_stack.sv =====
// Top level: value stack and minimum stack built from shifting cell chains.
//
//  channel | direction | beat contents
//  --------+-----------+-------------------------------------------
//  in      | sink      | opcode, push_value
//  out     | source    | top_value, min_value, is_empty, status
//
// One operation per cycle while in_stall is low; the result is registered in the
// output register from the accepted input beat, both chains shifting on that same edge.
// in_stall is high only while a result waits under out_stall.
// Reset clears both counts and out_valid; cell contents are not cleared.
`default_nettype none
module min_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        opcode,
  input  wire logic signed [31:0] push_value,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic signed [31:0] top_value,
  output      logic signed [31:0] min_value,
  output      logic        is_empty,
  output      logic [1:0]  status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] val_cnt, val_cnt_next;
  logic [CW-1:0] min_cnt, min_cnt_next;
  logic [31:0]   val_q0, val_q1, min_q0, min_q1;
  logic [31:0]   top_next, min_next;
  mts_pkg::shift_t  val_ctrl, min_ctrl;
  mts_pkg::status_t st_next;
  logic accept, val_full, val_empty, min_empty;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign val_full  = (val_cnt == CW'(STACK_DEPTH));
  assign val_empty = (val_cnt == '0);
  assign min_empty = (min_cnt == '0);

  always_comb begin
    val_ctrl = '0;
    min_ctrl = '0;
    st_next  = mts_pkg::ST_OK;
    if (opcode == mts_pkg::OP_PUSH) begin
      if (val_full) begin
        st_next = mts_pkg::ST_PUSH_FULL;
      end else begin
        val_ctrl.push = accept;
        min_ctrl.push = accept & (min_empty | ($signed(push_value) <= $signed(min_q0)));
      end
    end else begin
      if (val_empty) begin
        st_next = mts_pkg::ST_POP_EMPTY;
      end else begin
        val_ctrl.pop = accept;
        min_ctrl.pop = accept & ~min_empty & (val_q0 == min_q0);
      end
    end
  end

  always_comb begin
    val_cnt_next = val_cnt;
    min_cnt_next = min_cnt;
    if (val_ctrl.push) val_cnt_next = val_cnt + CW'(1);
    if (val_ctrl.pop)  val_cnt_next = val_cnt - CW'(1);
    if (min_ctrl.push) min_cnt_next = min_cnt + CW'(1);
    if (min_ctrl.pop)  min_cnt_next = min_cnt - CW'(1);

    // what the top cells will hold after this operation
    if (val_ctrl.push) begin
      top_next = push_value;
    end else if (val_ctrl.pop) begin
      top_next = (val_cnt > CW'(1)) ? val_q1 : mts_pkg::MOST_NEG;
    end else begin
      top_next = val_empty ? mts_pkg::MOST_NEG : val_q0;
    end

    if (min_ctrl.push) begin
      min_next = push_value;
    end else if (min_ctrl.pop) begin
      min_next = (min_cnt > CW'(1)) ? min_q1 : mts_pkg::MOST_NEG;
    end else begin
      min_next = min_empty ? mts_pkg::MOST_NEG : min_q0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_cnt   <= '0;
      min_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      val_cnt <= val_cnt_next;
      min_cnt <= min_cnt_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_value <= top_next;
      min_value <= min_next;
      is_empty  <= (val_cnt_next == '0);
      status    <= st_next;
    end
  end

  mts_chain #(.DEPTH(STACK_DEPTH)) u_val_chain (
    .clk  (clk),
    .ctrl (val_ctrl),
    .din  (push_value),
    .q0   (val_q0),
    .q1   (val_q1)
  );

  mts_chain #(.DEPTH(STACK_DEPTH)) u_min_chain (
    .clk  (clk),
    .ctrl (min_ctrl),
    .din  (push_value),
    .q0   (min_q0),
    .q1   (min_q1)
  );

endmodule
`default_nettype wire

// ===== rtl/mts_check.sv =====
// Port-level checks for the minimum-tracking stack, bound to the top level.
`default_nettype none
module mts_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] top_value,
  input wire logic [31:0] min_value,
  input wire logic        is_empty,
  input wire logic [1:0]  status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(top_value) && $stable(min_value))
    else $error("result changed while stalled");

  a_beat_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat gave no result");

  a_empty_reads: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> top_value == mts_pkg::MOST_NEG && min_value == mts_pkg::MOST_NEG)
    else $error("empty stack shows a value");

  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> $signed(min_value) <= $signed(top_value))
    else $error("minimum above top");

  a_pop_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mts_pkg::ST_POP_EMPTY |-> is_empty)
    else $error("refused pop on non-empty stack");

endmodule

bind min_tracking_stack mts_check u_mts_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .top_value (top_value),
  .min_value (min_value),
  .is_empty  (is_empty),
  .status    (status)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the minimum-tracking stack.
`timescale 1ns / 100ps
module tb_top;

  localparam int RANDOM_BEATS   = 1950;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 150;

  typedef struct packed {
    logic signed [31:0] top_v;
    logic signed [31:0] min_v;
    logic               empty_v;
    mts_pkg::status_t   status_v;
  } stack_view_t;

  typedef struct {
    logic        op;
    logic [31:0] val;
    logic        typed;
    stack_view_t want;
  } dir_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  localparam stack_view_t EMPTY_OK  =
    '{mts_pkg::MOST_NEG, mts_pkg::MOST_NEG, 1'b1, mts_pkg::ST_OK};
  localparam stack_view_t EMPTY_ERR =
    '{mts_pkg::MOST_NEG, mts_pkg::MOST_NEG, 1'b1, mts_pkg::ST_POP_EMPTY};
  localparam stack_view_t NO_VIEW   = '0;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               opcode     = mts_pkg::OP_PUSH;
  logic signed [31:0] push_value = '0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] top_value;
  logic signed [31:0] min_value;
  logic               is_empty;
  logic [1:0]         status;

  // shadow of both stacks
  logic [31:0] shadow_vals [mts_pkg::STACK_DEPTH];
  logic [31:0] shadow_mins [mts_pkg::STACK_DEPTH];
  int          shadow_depth     = 0;
  int          shadow_min_depth = 0;

  stack_view_t expected_views [$];
  stack_view_t monitor_want;
  int          mismatches     = 0;
  int          beats_in       = 0;
  int          burst_left     = 0;
  bit          long_hold_done = 1'b0;

  min_tracking_stack i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .top_value  (top_value),
    .min_value  (min_value),
    .is_empty   (is_empty),
    .status     (status)
  );

  always #1 clk = ~clk;

  function automatic stack_view_t minstack_apply(logic op, logic [31:0] x);
    stack_view_t v;
    v.status_v = mts_pkg::ST_OK;
    if (op == mts_pkg::OP_PUSH) begin
      if (shadow_depth >= mts_pkg::STACK_DEPTH) begin
        v.status_v = mts_pkg::ST_PUSH_FULL;
      end else begin
        shadow_vals[shadow_depth] = x;
        shadow_depth++;
        // ties go on the min stack too so a later pop of a duplicate keeps the min
        if (shadow_min_depth == 0 ||
            $signed(x) <= $signed(shadow_mins[shadow_min_depth - 1])) begin
          if (shadow_min_depth < mts_pkg::STACK_DEPTH) begin
            shadow_mins[shadow_min_depth] = x;
            shadow_min_depth++;
          end
        end
      end
    end else if (shadow_depth == 0) begin
      v.status_v = mts_pkg::ST_POP_EMPTY;
    end else begin
      shadow_depth--;
      if (shadow_min_depth > 0 &&
          shadow_vals[shadow_depth] == shadow_mins[shadow_min_depth - 1]) begin
        shadow_min_depth--;
      end
    end
    v.top_v   = (shadow_depth > 0) ? shadow_vals[shadow_depth - 1] : mts_pkg::MOST_NEG;
    v.min_v   = (shadow_min_depth > 0) ? shadow_mins[shadow_min_depth - 1]
                                       : mts_pkg::MOST_NEG;
    v.empty_v = (shadow_depth == 0);
    return v;
  endfunction

  // values aimed at the interesting spots: current min, its neighbors, top, extremes; also random and small ones
  function automatic logic [31:0] pick_value();
    logic [31:0] cur_min;
    logic [31:0] cur_top;
    cur_min = (shadow_min_depth > 0) ? shadow_mins[shadow_min_depth - 1] : '0;
    cur_top = (shadow_depth > 0) ? shadow_vals[shadow_depth - 1] : '0;
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: return $urandom_range(0, 16) - 32'd8;
      3: return cur_min;
      4: return cur_min - 32'd1;
      5: return cur_min + 32'd1;
      6: begin
        case ($urandom_range(0, 3))
          0: return mts_pkg::MOST_NEG;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return cur_top;
    endcase
  endfunction

  task automatic send_op(logic op, logic [31:0] val, logic typed, stack_view_t want);
    stack_view_t got;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid   <= 1'b1;
    opcode     <= op;
    push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = minstack_apply(op, val);
    expected_views.push_back(typed ? want : got);
    beats_in++;
  endtask

  // sender holds off until every result is back
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected (top %h min %h)",
                 $time, top_value, min_value);
      end else begin
        monitor_want = expected_views.pop_front();
        check_field("top_value", monitor_want.top_v, top_value);
        check_field("min_value", monitor_want.min_v, min_value);
        check_field("is_empty", 32'(monitor_want.empty_v), 32'(is_empty));
        check_field("status", 32'(monitor_want.status_v), 32'(status));
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int span;
    int mode;
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && beats_in >= 300) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      span = $urandom_range(10, 60);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("FAIL min_tracking_stack");
    $finish;
  end

  initial begin
    dir_row_t    dir_rows [22];
    phase_kind_t kind;
    int          phase;
    int          len;
    int          bias;
    int          random_sent;

    dir_rows = '{
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b1, EMPTY_ERR},
      '{mts_pkg::OP_POP,  32'hFFFF_FFFF, 1'b1, EMPTY_ERR},
      '{mts_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, mts_pkg::ST_OK}},
      '{mts_pkg::OP_PUSH, mts_pkg::MOST_NEG, 1'b1,
        '{mts_pkg::MOST_NEG, mts_pkg::MOST_NEG, 1'b0, mts_pkg::ST_OK}},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, mts_pkg::ST_OK}},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b1, EMPTY_OK},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b1, EMPTY_ERR},
      '{mts_pkg::OP_PUSH, 32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, 32'h0000_0005, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, 32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h1234_5678, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, mts_pkg::MOST_NEG, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0, NO_VIEW},
      '{mts_pkg::OP_PUSH, 32'h8000_0001, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{mts_pkg::OP_POP,  32'h0000_0000, 1'b0, NO_VIEW}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();

    // first two phases fill to overflow and drain to underflow, then a random mix
    phase = 0;
    random_sent = beats_in;
    while (beats_in - random_sent < RANDOM_BEATS) begin
      if (phase == 0) kind = PH_FILL;
      else if (phase == 1) kind = PH_DRAIN;
      else begin
        case ($urandom_range(0, 5))
          0: kind = PH_FILL;
          1: kind = PH_DRAIN;
          default: kind = PH_MIX;
        endcase
      end
      case (kind)
        PH_FILL: begin
          while (shadow_depth < mts_pkg::STACK_DEPTH) begin
            send_op(mts_pkg::OP_PUSH, pick_value(), 1'b0, NO_VIEW);
          end
          repeat ($urandom_range(1, 4)) send_op(mts_pkg::OP_PUSH, pick_value(), 1'b0, NO_VIEW);
        end
        PH_DRAIN: begin
          while (shadow_depth > 0) send_op(mts_pkg::OP_POP, $urandom(), 1'b0, NO_VIEW);
          repeat ($urandom_range(1, 4)) send_op(mts_pkg::OP_POP, $urandom(), 1'b0, NO_VIEW);
        end
        default: begin
          len  = $urandom_range(10, 80);
          bias = $urandom_range(25, 75);
          repeat (len) begin
            if ($urandom_range(0, 99) < bias) begin
              send_op(mts_pkg::OP_PUSH, pick_value(), 1'b0, NO_VIEW);
            end else begin
              send_op(mts_pkg::OP_POP, $urandom(), 1'b0, NO_VIEW);
            end
          end
        end
      endcase
      if ($urandom_range(0, 5) == 0) drain_results();
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS min_tracking_stack");
    end else begin
      $display("FAIL min_tracking_stack");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/mts_chain.sv
rtl/min_tracking_stack.sv
rtl/mts_check.sv
tb/tb_top.sv
